[hdl/cas_pkg.sv]
// Shared types, constants and the square-root step for the circle span generator.
`default_nettype none
package cas_pkg;

  localparam int ROW_W    = 12;
  localparam int COL_W    = 13;
  localparam int CX_W     = 16;
  localparam int R_W      = 15;
  localparam int SQ_W     = 2 * R_W;
  localparam int ROOT_W   = R_W;
  localparam int REM_W    = ROOT_W + 2;
  localparam int CNT_W    = 2;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_BITS_DEF = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_RING_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTER_RADIUS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_RADIUS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_ENABLE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_RIGHT   = 3'd7;

  typedef struct packed {
    logic                    ring_mode;
    logic signed [CX_W-1:0]  center_x;
    logic signed [CX_W-1:0]  center_y;
    logic [R_W-1:0]          outer_radius;
    logic [R_W-1:0]          inner_radius;
    logic                    clip_enable;
    logic signed [COL_W-1:0] clip_left;
    logic signed [COL_W-1:0] clip_right;
  } cas_cfg_t;

  typedef struct packed {
    logic              ok;
    logic [SQ_W-1:0]   n;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } cas_lane_t;

  typedef struct packed {
    cas_lane_t outer;
    cas_lane_t inner;
  } cas_lanes_t;

  // one digit of the integer square root: bring down two bits, try root*4+1
  function automatic cas_lane_t sq_step(input cas_lane_t a, input int step);
    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    cas_lane_t        b;
    rem_sh = {a.rem, a.n[2*step +: 2]};
    trial  = (REM_W+2)'({a.root, 2'b01});
    b      = a;
    if (rem_sh >= trial) begin
      b.rem  = REM_W'(rem_sh - trial);
      b.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      b.rem  = REM_W'(rem_sh);
      b.root = {a.root[ROOT_W-2:0], 1'b0};
    end
    return b;
  endfunction

endpackage
`default_nettype wire

[hdl/cas_if.sv]
// Row and span channel interfaces.
`default_nettype none
interface cas_row_if;
  import cas_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [ROW_W-1:0] row_y;
  modport source (output valid, output row_y, input ready);
  modport sink (input valid, input row_y, output ready);
endinterface

interface cas_span_if;
  import cas_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CNT_W-1:0]        span_count;
  logic signed [COL_W-1:0] first_left;
  logic signed [COL_W-1:0] first_right;
  logic signed [COL_W-1:0] second_left;
  logic signed [COL_W-1:0] second_right;
  modport source (output valid, output span_count, output first_left, output first_right,
                  output second_left, output second_right, input ready);
  modport sink (input valid, input span_count, input first_left, input first_right,
                input second_left, input second_right, output ready);
endinterface
`default_nettype wire

[hdl/circle_annulus_span_gen.sv]
// Top level: configuration registers, front stages, square-root cell row, span back end.
// Registers from row word to span word: 3 front, 15 root cells, 2 back.
// Throughput: one row word per cycle unless stalled; each root cell adds one digit.
// A stalled output holds its word while earlier stages keep filling their empty slots.
// Reset (synchronous, rst high) clears all configuration registers and all valid flags.
`default_nettype none
module circle_annulus_span_gen #(
  parameter int FRAC_BITS = cas_pkg::FRAC_BITS_DEF
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            cfg_write,
  input  wire [cas_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [cas_pkg::CFG_W-1:0]       cfg_data,
  cas_row_if.sink                        rows,
  cas_span_if.source                     spans
);
  import cas_pkg::*;

  cas_cfg_t   cfg;
  logic       cv [0:ROOT_W];
  logic       cr [0:ROOT_W];
  cas_lanes_t cd [0:ROOT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_RING_MODE:    cfg.ring_mode    <= cfg_data[0];
        CFG_CENTER_X:     cfg.center_x     <= cfg_data[CX_W-1:0];
        CFG_CENTER_Y:     cfg.center_y     <= cfg_data[CX_W-1:0];
        CFG_OUTER_RADIUS: cfg.outer_radius <= cfg_data[R_W-1:0];
        CFG_INNER_RADIUS: cfg.inner_radius <= cfg_data[R_W-1:0];
        CFG_CLIP_ENABLE:  cfg.clip_enable  <= cfg_data[0];
        CFG_CLIP_LEFT:    cfg.clip_left    <= cfg_data[COL_W-1:0];
        CFG_CLIP_RIGHT:   cfg.clip_right   <= cfg_data[COL_W-1:0];
        default: ;
      endcase
    end
  end

  cas_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .rows(rows),
    .out_valid(cv[0]), .out_ready(cr[0]), .out_data(cd[0])
  );

  for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
    cas_cell #(.STEP(ROOT_W - 1 - k)) u_cell (
      .clk(clk), .rst(rst),
      .in_valid(cv[k]), .in_ready(cr[k]), .in_data(cd[k]),
      .out_valid(cv[k+1]), .out_ready(cr[k+1]), .out_data(cd[k+1])
    );
  end

  cas_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(cv[ROOT_W]), .in_ready(cr[ROOT_W]), .in_data(cd[ROOT_W]),
    .spans(spans)
  );

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    spans.valid |-> spans.span_count != 2'd3)
    else $error("span count out of range");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (spans.valid && spans.span_count == 2'd0) |->
      (spans.first_left == '0 && spans.first_right == '0))
    else $error("unused first slot not zero");

  a_second_zero: assert property (@(posedge clk) disable iff (rst)
    (spans.valid && spans.span_count != 2'd2) |->
      (spans.second_left == '0 && spans.second_right == '0))
    else $error("unused second slot not zero");

  a_first_order: assert property (@(posedge clk) disable iff (rst)
    (spans.valid && spans.span_count != 2'd0) |-> spans.first_left < spans.first_right)
    else $error("first span empty");

endmodule
`default_nettype wire

[hdl/cas_front.sv]
// Row offset, squares and radicands ahead of the square-root cells.
`default_nettype none
module cas_front #(
  parameter int FRAC_BITS = cas_pkg::FRAC_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  cas_pkg::cas_cfg_t   cfg,
  cas_row_if.sink             rows,
  output logic                out_valid,
  input  wire                 out_ready,
  output cas_pkg::cas_lanes_t out_data
);
  import cas_pkg::*;

  localparam int SH_W = ROW_W + FRAC_BITS;
  localparam int DY_W = ((SH_W > CX_W) ? SH_W : CX_W) + 1;
  localparam int P_W  = 2 * DY_W;

  logic                   v1, v2, v3;
  logic                   rdy1, rdy2, rdy3;
  logic signed [DY_W-1:0] dy;
  logic signed [DY_W-1:0] dy_next;
  logic [DY_W-1:0]        dy_mag;
  logic [P_W-1:0]         dy2;
  logic [SQ_W-1:0]        ro2, ri2;
  cas_lanes_t             lanes_next;

  assign rdy3 = !v3 || out_ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign rows.ready = rdy1;
  assign out_valid = v3;

  assign dy_next = (DY_W'(rows.row_y) <<< FRAC_BITS) - DY_W'(cfg.center_y);
  assign dy_mag  = dy[DY_W-1] ? DY_W'(-dy) : DY_W'(dy);

  always_comb begin
    lanes_next = '0;
    lanes_next.outer.ok = (P_W'(ro2) >= dy2);
    lanes_next.outer.n  = ro2 - dy2[SQ_W-1:0];
    lanes_next.inner.ok = (P_W'(ri2) >= dy2);
    lanes_next.inner.n  = ri2 - dy2[SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= rows.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && rows.valid) dy <= dy_next;
    if (rdy2 && v1) begin
      dy2 <= dy_mag * dy_mag;
      ro2 <= cfg.outer_radius * cfg.outer_radius;
      ri2 <= cfg.inner_radius * cfg.inner_radius;
    end
    if (rdy3 && v2) out_data <= lanes_next;
  end

endmodule
`default_nettype wire

[hdl/cas_cell.sv]
// One square-root digit cell for the outer and inner lanes.
`default_nettype none
module cas_cell #(
  parameter int STEP = 0
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  cas_pkg::cas_lanes_t in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output cas_pkg::cas_lanes_t out_data
);
  import cas_pkg::*;

  logic valid;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data.outer <= sq_step(in_data.outer, STEP);
      out_data.inner <= sq_step(in_data.inner, STEP);
    end
  end

endmodule
`default_nettype wire

[hdl/cas_back.sv]
// Edge columns, clipping and span packing into the output register.
`default_nettype none
module cas_back #(
  parameter int FRAC_BITS = cas_pkg::FRAC_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  cas_pkg::cas_cfg_t   cfg,
  input  wire                 in_valid,
  output logic                in_ready,
  input  cas_pkg::cas_lanes_t in_data,
  cas_span_if.source          spans
);
  import cas_pkg::*;

  localparam int EW   = CX_W + 2;
  localparam int HALF = (1 << FRAC_BITS) >> 1;
  localparam logic signed [EW-1:0] RND    = EW'((1 << FRAC_BITS) - 1);
  localparam logic signed [EW-1:0] HALF_E = EW'(HALF);
  localparam logic signed [EW-1:0] COL_LO = EW'(-(1 << (COL_W - 1)));
  localparam logic signed [EW-1:0] COL_HI = EW'((1 << (COL_W - 1)) - 1);

  function automatic logic signed [COL_W-1:0] to_col(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] q;
    q = v[EW-1] ? ((v + RND) >>> FRAC_BITS) : (v >>> FRAC_BITS);
    if (q < COL_LO) return COL_LO[COL_W-1:0];
    if (q > COL_HI) return COL_HI[COL_W-1:0];
    return q[COL_W-1:0];
  endfunction

  logic                    v1, v2, rdy1, rdy2;
  logic                    ok_o, ok_i;
  logic signed [COL_W-1:0] ol, orr, il, ir;
  logic signed [EW-1:0]    cx, ho, hi;
  logic signed [COL_W-1:0] cl_l, cl_r;
  logic signed [COL_W-1:0] a_l, a_r, b_l, b_r;
  logic                    a_ok, b_ok, ring;
  logic [CNT_W-1:0]        cnt_next;
  logic signed [COL_W-1:0] fl_next, fr_next, sl_next, sr_next;

  assign rdy2 = !v2 || spans.ready;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;
  assign spans.valid = v2;

  assign cx = EW'(cfg.center_x);
  assign ho = EW'(in_data.outer.root);
  assign hi = EW'(in_data.inner.root);

  always_comb begin
    cl_l = ol;
    cl_r = orr;
    if (cfg.clip_enable) begin
      if (ol < cfg.clip_left) cl_l = cfg.clip_left;
      if (orr > cfg.clip_right) cl_r = cfg.clip_right;
    end
    ring = cfg.ring_mode && ok_i;
    a_l  = cl_l;
    a_r  = ring ? il : cl_r;
    b_l  = ir;
    b_r  = cl_r;
    a_ok = ok_o && (a_l < a_r);
    b_ok = ok_o && ring && (b_l < b_r);
    fl_next = '0;
    fr_next = '0;
    sl_next = '0;
    sr_next = '0;
    cnt_next = '0;
    if (a_ok) begin
      fl_next = a_l;
      fr_next = a_r;
      if (b_ok) begin
        sl_next = b_l;
        sr_next = b_r;
        cnt_next = CNT_W'(2);
      end else begin
        cnt_next = CNT_W'(1);
      end
    end else if (b_ok) begin
      fl_next = b_l;
      fr_next = b_r;
      cnt_next = CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      ok_o <= in_data.outer.ok;
      ok_i <= in_data.inner.ok;
      ol   <= to_col(cx - ho);
      orr  <= to_col(cx + ho);
      il   <= to_col(cx - hi + HALF_E);
      ir   <= to_col(cx + hi + HALF_E);
    end
    if (rdy2 && v1) begin
      spans.span_count   <= cnt_next;
      spans.first_left   <= fl_next;
      spans.first_right  <= fr_next;
      spans.second_left  <= sl_next;
      spans.second_right <= sr_next;
    end
  end

endmodule
`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for the circle and annulus span generator.
module testbench;
  import cas_pkg::*;

  localparam int     FRAC       = FRAC_BITS_DEF;
  localparam longint ONE_PX     = longint'(1) << FRAC;
  localparam longint HALF_PX    = ONE_PX >> 1;
  localparam longint COL_LO     = -(longint'(1) << (COL_W - 1));
  localparam longint COL_HI     = (longint'(1) << (COL_W - 1)) - 1;
  localparam int     HOLD_LEN   = 120;
  localparam int     TAIL_WAIT  = 40;

  typedef struct packed {
    logic [CNT_W-1:0]        count;
    logic signed [COL_W-1:0] first_left;
    logic signed [COL_W-1:0] first_right;
    logic signed [COL_W-1:0] second_left;
    logic signed [COL_W-1:0] second_right;
  } span_word_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  cas_row_if  row_ch();
  cas_span_if span_ch();

  circle_annulus_span_gen uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rows      (row_ch),
    .spans     (span_ch)
  );

  cas_cfg_t   geometry;
  span_word_t pending_spans[$];
  int         mismatches;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         hold_requests;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

  function automatic int rand_between(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // largest x with x*x <= n
  function automatic longint floor_root(input longint n);
    longint lo;
    longint hi;
    longint mid;
    lo = 0;
    hi = 32768;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (mid * mid <= n) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic longint to_column(input longint v);
    longint c;
    c = v / ONE_PX;
    if (c < COL_LO) c = COL_LO;
    if (c > COL_HI) c = COL_HI;
    return c;
  endfunction

  function automatic void append_span(inout span_word_t w, input longint l, input longint r);
    if (l >= r) return;
    if (w.count == 0) begin
      w.first_left  = COL_W'(l);
      w.first_right = COL_W'(r);
    end else begin
      w.second_left  = COL_W'(l);
      w.second_right = COL_W'(r);
    end
    w.count = w.count + 1'b1;
  endfunction

  function automatic span_word_t predict_spans(input logic signed [ROW_W-1:0] row);
    longint     cx;
    longint     dy;
    longint     ro;
    longint     ri;
    longint     reach2;
    longint     hole2;
    longint     hw;
    longint     ol;
    longint     orr;
    span_word_t w;
    w      = '0;
    cx     = longint'($signed(geometry.center_x));
    dy     = longint'(row) * ONE_PX - longint'($signed(geometry.center_y));
    ro     = longint'(geometry.outer_radius);
    ri     = longint'(geometry.inner_radius);
    reach2 = ro * ro - dy * dy;
    if (reach2 >= 0) begin
      hw  = floor_root(reach2);
      ol  = to_column(cx - hw);
      orr = to_column(cx + hw);
      if (geometry.clip_enable) begin
        if (ol < longint'($signed(geometry.clip_left))) ol = longint'($signed(geometry.clip_left));
        if (orr > longint'($signed(geometry.clip_right)))
          orr = longint'($signed(geometry.clip_right));
      end
      hole2 = ri * ri - dy * dy;
      if (geometry.ring_mode && hole2 >= 0) begin
        hw = floor_root(hole2);
        append_span(w, ol, to_column(cx - hw + HALF_PX));
        append_span(w, to_column(cx + hw + HALF_PX), orr);
      end else begin
        append_span(w, ol, orr);
      end
    end
    return w;
  endfunction

  function automatic cas_cfg_t make_geometry(input bit ring, input int cx, input int cy,
                                             input int ro, input int ri, input bit clip_on,
                                             input int cl, input int cr);
    cas_cfg_t c;
    c.ring_mode    = ring;
    c.center_x     = CX_W'(cx);
    c.center_y     = CX_W'(cy);
    c.outer_radius = R_W'(ro);
    c.inner_radius = R_W'(ri);
    c.clip_enable  = clip_on;
    c.clip_left    = COL_W'(cl);
    c.clip_right   = COL_W'(cr);
    return c;
  endfunction

  function automatic cas_cfg_t random_geometry();
    int ro;
    int ri;
    int cx;
    int cy;
    int cl;
    int cr;
    case ($urandom_range(3))
      0:       ro = rand_between(0, 48);
      1:       ro = rand_between(0, 1200);
      2:       ro = rand_between(0, 16000);
      default: ro = rand_between(0, 32767);
    endcase
    ri = ($urandom_range(4) == 0) ? rand_between(0, 32767) : rand_between(0, ro);
    cx = ($urandom_range(3) == 0) ? rand_between(-32768, 32767) : rand_between(-4000, 4000);
    cy = ($urandom_range(3) == 0) ? rand_between(-32768, 32767) : rand_between(-4000, 4000);
    cl = ($urandom_range(4) == 0) ? rand_between(-4096, 4095) : cx / 16 + rand_between(-120, 40);
    cr = ($urandom_range(4) == 0) ? rand_between(-4096, 4095) : cx / 16 + rand_between(-40, 120);
    return make_geometry(1'($urandom_range(1)), cx, cy, ro, ri, 1'($urandom_range(1)), cl, cr);
  endfunction

  // mostly rows that cut the shape, some anywhere
  function automatic int random_row();
    int mid;
    int reach;
    int r;
    if ($urandom_range(4) == 0) return rand_between(-2048, 2047);
    mid   = int'($signed(geometry.center_y)) / 16;
    reach = int'(geometry.outer_radius) / 16 + 2;
    r     = mid + rand_between(-reach, reach);
    if (r < -2048) r = -2048;
    if (r > 2047) r = 2047;
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [COL_W:0] want,
                             input logic signed [COL_W:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_span();
    span_word_t want;
    if (pending_spans.size() == 0) begin
      $error("span word with no row pending");
      mismatches++;
      return;
    end
    want = pending_spans.pop_front();
    check_field("span_count", want.count, span_ch.span_count);
    check_field("first_left", want.first_left, span_ch.first_left);
    check_field("first_right", want.first_right, span_ch.first_right);
    check_field("second_left", want.second_left, span_ch.second_left);
    check_field("second_right", want.second_right, span_ch.second_right);
  endtask

  initial begin : span_sink
    int holds_served;
    int hold_left;
    holds_served  = 0;
    hold_left     = 0;
    span_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && span_ch.valid && span_ch.ready) check_span();
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        span_ch.ready <= 1'b0;
      end else begin
        span_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  task automatic send_row(input int row);
    span_word_t expected;
    while ($urandom_range(99) < send_idle_pct) begin
      row_ch.valid <= 1'b0;
      @(posedge clk);
    end
    row_ch.valid <= 1'b1;
    row_ch.row_y <= ROW_W'(row);
    do @(posedge clk); while (!row_ch.ready);
    expected = predict_spans(ROW_W'(row));
    pending_spans.insert(pending_spans.size(), expected);
  endtask

  task automatic drain_rows();
    row_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_spans.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic load_geometry(input cas_cfg_t c);
    write_reg(CFG_RING_MODE, CFG_W'(c.ring_mode));
    write_reg(CFG_CENTER_X, CFG_W'(c.center_x));
    write_reg(CFG_CENTER_Y, CFG_W'(c.center_y));
    write_reg(CFG_OUTER_RADIUS, CFG_W'(c.outer_radius));
    write_reg(CFG_INNER_RADIUS, CFG_W'(c.inner_radius));
    write_reg(CFG_CLIP_ENABLE, CFG_W'(c.clip_enable));
    write_reg(CFG_CLIP_LEFT, CFG_W'(c.clip_left));
    write_reg(CFG_CLIP_RIGHT, CFG_W'(c.clip_right));
    cfg_write <= 1'b0;
    geometry = c;
  endtask

  task automatic test_reset_state();
    send_row(0);
    send_row(-2048);
    send_row(2047);
    drain_rows();
  endtask

  task automatic test_filled_circle();
    load_geometry(make_geometry(0, 168, 80, 80, 0, 0, 0, 0));
    send_row(5);
    send_row(0);
    send_row(-1);
    send_row(3);
    send_row(9);
    drain_rows();
  endtask

  task automatic test_annulus();
    load_geometry(make_geometry(1, -200, 0, 160, 80, 0, 0, 0));
    send_row(0);
    send_row(4);
    send_row(7);
    send_row(10);
    send_row(-10);
    drain_rows();
    load_geometry(make_geometry(1, 0, 0, 160, 200, 0, 0, 0));
    send_row(0);
    send_row(9);
    drain_rows();
  endtask

  task automatic test_clipping();
    load_geometry(make_geometry(0, 0, 0, 1600, 0, 1, -20, 30));
    send_row(0);
    send_row(99);
    drain_rows();
    load_geometry(make_geometry(0, 0, 0, 1600, 0, 1, 30, -20));
    send_row(0);
    drain_rows();
    load_geometry(make_geometry(1, 0, 0, 1600, 800, 1, -4096, 20));
    send_row(0);
    drain_rows();
  endtask

  task automatic test_saturation();
    load_geometry(make_geometry(1, 32767, 0, 32767, 32000, 0, 0, 0));
    send_row(0);
    drain_rows();
    load_geometry(make_geometry(0, -32768, -32768, 32767, 0, 1, -4096, 4095));
    send_row(-2048);
    send_row(0);
    drain_rows();
    load_geometry(make_geometry(1, 32767, 32767, 32767, 32767, 0, 0, 0));
    send_row(2047);
    drain_rows();
  endtask

  task automatic test_random_rows(input int shapes, input int rows_per_shape);
    repeat (shapes) begin
      load_geometry(random_geometry());
      repeat (rows_per_shape) send_row(random_row());
      drain_rows();
    end
  endtask

  // stall the span side long enough to back up the row side
  task automatic test_backpressure();
    load_geometry(random_geometry());
    hold_requests <= hold_requests + 1;
    repeat (80) send_row(random_row());
    drain_rows();
  endtask

  initial begin
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    row_ch.valid  = 1'b0;
    row_ch.row_y  = '0;
    mismatches    = 0;
    hold_requests = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    geometry      = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    set_idling(21, 69);
    test_reset_state();
    test_filled_circle();
    test_annulus();
    test_clipping();
    test_saturation();
    test_random_rows(13, 30);
    set_idling(69, 21);
    test_random_rows(13, 30);
    set_idling(0, 0);
    test_random_rows(13, 30);
    test_backpressure();
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
